// ===== rtl/sorted_key_table_top_defines.svh =====
// Assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the next cycle
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_table check failed");
// Assert that a condition holds at every edge
`define SKT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted_key_table check failed");
`endif

// ===== rtl/skt_pkg.sv =====
// Shared types and codes of the sorted key table
package skt_pkg;
  localparam int KEY_BITS = 160;
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;
endpackage

// ===== rtl/sorted_key_table_top.sv =====
// Sorted key table: sequencer around one entry memory
// Sorted table of 160-bit keys with payloads, held in one memory (key and payload
// in one word). A request is taken when start is high and busy is low; one result
// appears for one cycle with out_valid, and cannot be stalled. A request runs a
// binary search over the occupied entries, each probe waiting for the registered
// memory read, at most ceil(log2(TABLE_DEPTH))+1 probes, then a decide state that
// registers the result. An insert of a new key or a remove then shifts the entries
// above the position one at a time through the memory's one write port, and an
// insert with a shift then writes the new key in its slot, before busy falls.
`include "sorted_key_table_top_defines.svh"
module sorted_key_table_top import skt_pkg::*; #(
  parameter int TABLE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_middle,
  input  logic [31:0] in_key_low,
  input  logic [15:0] in_payload_in,
  input  logic        in_keep_existing,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [6:0]  out_position,
  output logic [15:0] out_payload_out
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PB = (PAYLOAD_BITS < 16) ? PAYLOAD_BITS : 16;
  localparam int WW = KEY_BITS + PB;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_WAIT, S_DECIDE, S_SHREAD, S_SHWAIT, S_FILL
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r, lo_r, hi_r, mid_r, pos_r, idx_r;
  logic [1:0] func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [PB-1:0] pin_r;
  logic keep_r;
  logic [1:0] status_r;
  logic found_r, valid_r;
  logic [6:0] position_r;
  logic [15:0] pout_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [KEY_BITS-1:0] rkey;
  logic [PB-1:0] rpay;

  skt_ram #(.WIDTH(WW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rkey = rdata[WW-1:PB];
  assign rpay = rdata[PB-1:0];
  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_found = found_r;
  assign out_position = position_r;
  assign out_payload_out = pout_r;

  logic [CW-1:0] midsum;
  assign midsum = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    raddr = midsum[AW-1:0];
    if (state_r == S_SHREAD) begin
      raddr = (func_r == FUNC_INSERT) ? AW'(idx_r - 1'b1) : AW'(idx_r + 1'b1);
    end
    if (state_r == S_SHWAIT) begin
      we = 1'b1;
    end
    if (state_r == S_FILL) begin
      we = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = {key_r, pin_r};
    end
    if (state_r == S_DECIDE) begin
      waddr = pos_r[AW-1:0];
      if (func_r == FUNC_INSERT && found_r && !keep_r) begin
        we = 1'b1;
        wdata = {key_r, pin_r};
      end else if (func_r == FUNC_INSERT && !found_r && count_r != DEPTH_C
                   && pos_r == count_r) begin
        we = 1'b1;
        wdata = {key_r, pin_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (state_r == S_DECIDE);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r <= in_func;
            key_r <= {in_key_high, in_key_middle, in_key_low};
            pin_r <= in_payload_in[PB-1:0];
            keep_r <= in_keep_existing;
            lo_r <= '0;
            hi_r <= count_r;
            found_r <= 1'b0;
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo_r < hi_r) begin
            mid_r <= midsum;
            state_r <= S_WAIT;
          end else begin
            pos_r <= lo_r;
            state_r <= S_DECIDE;
          end
        end
        S_WAIT: begin
          state_r <= S_PROBE;
          if (rkey == key_r) begin
            found_r <= 1'b1;
            pos_r <= mid_r;
            pout_r <= 16'(rpay);
            state_r <= S_DECIDE;
          end else if (key_r < rkey) begin
            hi_r <= mid_r;
          end else begin
            lo_r <= mid_r + 1'b1;
          end
        end
        S_DECIDE: begin
          position_r <= 7'(pos_r);
          pout_r <= found_r ? pout_r : 16'd0;
          state_r <= S_IDLE;
          case (func_r)
            FUNC_INSERT: begin
              if (found_r) begin
                status_r <= ST_DUP;
              end else if (count_r == DEPTH_C) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_DONE;
                count_r <= count_r + 1'b1;
                if (pos_r != count_r) begin
                  idx_r <= count_r;
                  state_r <= S_SHREAD;
                end
              end
            end
            FUNC_REMOVE: begin
              status_r <= found_r ? ST_DONE : ST_MISS;
              if (found_r) begin
                count_r <= count_r - 1'b1;
                if (pos_r + 1'b1 < count_r) begin
                  idx_r <= pos_r;
                  state_r <= S_SHREAD;
                end
              end
            end
            default: status_r <= found_r ? ST_DONE : ST_MISS;
          endcase
        end
        S_SHREAD: state_r <= S_SHWAIT;
        S_SHWAIT: begin
          // advance the shift; for an insert, write the new key at its slot when done
          state_r <= S_SHREAD;
          if (func_r == FUNC_INSERT) begin
            idx_r <= idx_r - 1'b1;
            if (idx_r - 1'b1 == pos_r) begin
              state_r <= S_FILL;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            if (idx_r + 1'b1 >= count_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FILL: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SKT_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C)
  `SKT_ASSERT_NEXT(a_one_result, valid_r, !valid_r)
  `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
endmodule

// ===== rtl/skt_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== bench/tb_sorted_key_table_top.sv =====
// Self-checking testbench for the sorted key table: random and directed requests, queued checks
module tb_sorted_key_table_top;
  import skt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int ITEMS = 1600;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] kh;
    logic [63:0] km;
    logic [31:0] kl;
    logic [15:0] pay;
    logic        keep;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [6:0]  position;
    logic [15:0] payload;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_middle = '0;
  logic [31:0] in_key_low = '0;
  logic [15:0] in_payload_in = '0;
  logic in_keep_existing = 1'b0;
  logic out_valid;
  logic [1:0] out_status;
  logic out_found;
  logic [6:0] out_position;
  logic [15:0] out_payload_out;

  sorted_key_table_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t pending_requests[$];
  answer_t expected_answers[$];
  logic [159:0] table_keys[DEPTH];
  logic [15:0] table_payloads[DEPTH];
  int entry_total = 0;
  int mismatches = 0;
  int answers_seen = 0;
  int cycles = 0;
  int hits_seen = 0;
  int full_seen = 0;
  bit quiet = 1'b0;
  bit done_feeding = 1'b0;
  logic [159:0] key_pool[$];

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    logic [159:0] k;
    int lo, hi, mid;
    bit hit;
    k = {r.kh, r.km, r.kl};
    lo = 0;
    hi = entry_total;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (k == table_keys[mid]) begin
        hit = 1'b1;
        lo = mid;
      end else if (k < table_keys[mid]) hi = mid;
      else lo = mid + 1;
    end
    a.found = hit;
    a.position = lo[6:0];
    a.payload = hit ? table_payloads[lo] : 16'd0;
    if (r.func == FUNC_INSERT) begin
      if (hit) begin
        a.status = ST_DUP;
        if (!r.keep) table_payloads[lo] = r.pay;
      end else if (entry_total >= DEPTH) begin
        a.status = ST_FULL;
      end else begin
        for (int i = entry_total; i > lo; i--) begin
          table_keys[i] = table_keys[i-1];
          table_payloads[i] = table_payloads[i-1];
        end
        table_keys[lo] = k;
        table_payloads[lo] = r.pay;
        entry_total++;
        a.status = ST_DONE;
      end
    end else if (r.func == FUNC_REMOVE) begin
      if (hit) begin
        for (int i = lo; i + 1 < entry_total; i++) begin
          table_keys[i] = table_keys[i+1];
          table_payloads[i] = table_payloads[i+1];
        end
        entry_total--;
        a.status = ST_DONE;
      end else a.status = ST_MISS;
    end else a.status = hit ? ST_DONE : ST_MISS;
    return a;
  endfunction

  function automatic logic [159:0] random_key();
    logic [159:0] k;
    int sel;
    sel = $urandom_range(0, 9);
    k = {$urandom, $urandom, $urandom, $urandom, $urandom};
    if (key_pool.size() > 0 && sel < 6) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (sel == 5) k[$urandom_range(0, 159)] ^= 1'b1;
    end else if (sel == 6) begin
      k[159:32] = '0;
    end else if (sel == 7) begin
      k[159:32] = '1;
    end
    return k;
  endfunction

  task automatic add_request(logic [1:0] f, logic [159:0] k, logic [15:0] p, logic kp);
    request_t r;
    r.func = f;
    {r.kh, r.km, r.kl} = k;
    r.pay = p;
    r.keep = kp;
    pending_requests.push_back(r);
    if (f == FUNC_INSERT && key_pool.size() < 200) key_pool.push_back(k);
  endtask

  // Driver
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!busy && pending_requests.size() > 0 &&
                 (quiet || $urandom_range(0, 99) >= 12)) begin
      r = pending_requests.pop_front();
      expected_answers.push_back(apply_request(r));
      start <= 1'b1;
      in_func <= r.func;
      in_key_high <= r.kh;
      in_key_middle <= r.km;
      in_key_low <= r.kl;
      in_payload_in <= r.pay;
      in_keep_existing <= r.keep;
    end else begin
      start <= 1'b0;
      in_func <= 2'($urandom);
      in_key_high <= {$urandom, $urandom};
    end
  end

  // Monitor
  always @(posedge clk) begin
    answer_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      answers_seen <= answers_seen + 1;
      if (expected_answers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transaction: status %0d", out_status);
      end else begin
        e = expected_answers.pop_front();
        if (e.found) hits_seen <= hits_seen + 1;
        if (e.status == ST_FULL) full_seen <= full_seen + 1;
        if (out_status !== e.status || out_found !== e.found ||
            out_position !== e.position || out_payload_out !== e.payload) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp st %0d f %0d pos %0d pay %h, got st %0d f %0d pos %0d pay %h",
                     e.status, e.found, e.position, e.payload,
                     out_status, out_found, out_position, out_payload_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [159:0] k;
    int n;
    // directed: extremes, every operation, unused code, duplicates, misses
    add_request(FUNC_LOOKUP, '0, 16'h0, 1'b0);
    add_request(FUNC_REMOVE, '1, 16'h0, 1'b0);
    add_request(FUNC_INSERT, '0, 16'hFFFF, 1'b0);
    add_request(FUNC_INSERT, '1, 16'h0001, 1'b1);
    add_request(FUNC_INSERT, {64'h8000_0000_0000_0000, 96'h0}, 16'h8000, 1'b0);
    add_request(FUNC_LOOKUP, '1, 16'h0, 1'b0);
    add_request(2'd3, '0, 16'hFFFF, 1'b1);
    add_request(FUNC_INSERT, '1, 16'h1234, 1'b1);
    add_request(FUNC_INSERT, '1, 16'h5678, 1'b0);
    add_request(FUNC_LOOKUP, '1, 16'h0, 1'b0);
    add_request(FUNC_LOOKUP, 160'h5, 16'h0, 1'b0);
    add_request(FUNC_REMOVE, '0, 16'h0, 1'b0);
    add_request(FUNC_REMOVE, '0, 16'h0, 1'b0);
    add_request(FUNC_LOOKUP, {64'h8000_0000_0000_0000, 96'h0}, 16'h0, 1'b0);
    // fill to capacity, then hit full
    for (int i = 0; i < DEPTH + 4; i++)
      add_request(FUNC_INSERT, {$urandom, $urandom, $urandom, $urandom, $urandom},
                  16'($urandom), 1'($urandom));
    add_request(FUNC_INSERT, '0, 16'hAAAA, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      add_request(FUNC_REMOVE, key_pool[i], 16'h0, 1'b0);
    key_pool.delete();
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    for (int i = 0; i < ITEMS; i++) begin
      if (i >= 600 && i < 900) quiet = 1'b1;
      else quiet = 1'b0;
      n = $urandom_range(0, 99);
      k = random_key();
      if (n < 40) add_request(FUNC_LOOKUP, k, 16'($urandom), 1'($urandom));
      else if (n < 75 || (i / 200) % 2 == 0 && n < 85)
        add_request(FUNC_INSERT, k, 16'($urandom), 1'($urandom));
      else if (n < 97) add_request(FUNC_REMOVE, k, 16'($urandom), 1'($urandom));
      else add_request(2'd3, k, 16'($urandom), 1'($urandom));
      wait (pending_requests.size() < 4);
    end
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    repeat (400) @(posedge clk);
    $display("ran %0d requests in %0d cycles: %0d hits, %0d full rejections",
             answers_seen, cycles, hits_seen, full_seen);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/sorted_key_table_top.sv
bench/tb_sorted_key_table_top.sv
